// ===== rtl/core/rlps_pkg.sv =====
// Shared types and constants for the RGB LED pulse serializer.
// No dependencies; compiled first.
package rlps_pkg;

   localparam int PIXEL_BITS  = 24;
   localparam int BIT_CNT_W   = 5;
   localparam int TICK_W      = 8;
   localparam int COLOR_W     = 8;
   localparam int CSR_ADDR_W  = 8;
   localparam int CSR_DATA_W  = 8;
   localparam int QUEUE_DEPTH = 2;

   // item kinds on the request channel
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_HIGH = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_LOW  = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ONE_HIGH  = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ONE_LOW   = 8'd3;

   localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd4;
   localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 8'd14;
   localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd11;
   localparam logic [TICK_W-1:0] ONE_LOW_RST   = 8'd9;

   // classified command passed from front to back through the queue
   typedef struct packed {
      logic                  is_tick;
      logic [PIXEL_BITS-1:0] grb;
   } cmd_type;

   // queue handshake as seen from one side
   typedef struct packed {
      logic valid;
      logic ready;
   } hs_type;

endpackage

// ===== rtl/core/rlps_ifs.sv =====
// Channel interfaces: request, response and register write.
// Depends on rlps_pkg.
interface rlps_req_if;
   import rlps_pkg::*;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   modport source (output valid, req_type, red, green, blue, input ready);
   modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface rlps_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic pixel_taken;
   logic sending;
   modport source (output valid, line_level, pixel_taken, sending, input ready);
   modport sink   (input valid, line_level, pixel_taken, sending, output ready);
endinterface

interface rlps_csr_if;
   import rlps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rgb_led_pulse_serializer.sv =====
// Top level of the RGB LED pulse serializer: front end, command queue and
// serializer engine. Depends on rlps_pkg, the channel interfaces and submodules.
//
// Each request is either a pixel offer or one line tick, and each produces
// exactly one response carrying the data line level, whether the pixel was
// taken and whether a pixel is still being sent. The block sustains one
// request per clock cycle while the queue has room and responses are taken:
// the engine updates the bit and phase state once per command, and a response
// register decoupled by the command queue lets requests keep flowing while a
// response waits, until the queue fills. A request is written into the queue
// and its response is registered when the engine pops it. Register writes
// take effect on the next phase loaded; the csr channel is always ready.
module rgb_led_pulse_serializer #(
   parameter int QueueDepth = rlps_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   rlps_req_if.sink     req_bus,
   rlps_rsp_if.source   rsp_bus,
   rlps_csr_if.sink     csr_bus
);
   import rlps_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   hs_type  push_hs;
   logic    q_not_full;
   logic    q_not_empty;
   logic    q_pop;

   rlps_front u_front (
      .req_bus (req_bus),
      .cmd_out (front_cmd),
      .push_hs (push_hs),
      .q_ready (q_not_full)
   );

   rlps_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_hs.valid && push_hs.ready),
      .push_data (front_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .pop_data  (queue_cmd),
      .not_empty (q_not_empty)
   );

   rlps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_in    (queue_cmd),
      .cmd_valid (q_not_empty),
      .cmd_pop   (q_pop),
      .csr_bus   (csr_bus),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== rtl/core/rlps_front.sv =====
// Front end: takes request transfers, classifies them and packs pixels in
// green-red-blue send order for the command queue. Depends on rlps_pkg.
module rlps_front (
   rlps_req_if.sink           req_bus,
   output rlps_pkg::cmd_type  cmd_out,
   output rlps_pkg::hs_type   push_hs,
   input  logic               q_ready
);
   import rlps_pkg::*;

   assign req_bus.ready  = q_ready;
   assign push_hs.valid  = req_bus.valid;
   assign push_hs.ready  = q_ready;
   assign cmd_out.is_tick = (req_bus.req_type == REQ_TICK);
   assign cmd_out.grb     = {req_bus.green, req_bus.red, req_bus.blue};

endmodule

// ===== rtl/core/rlps_queue.sv =====
// Small register FIFO between front end and serializer engine.
// Depends on rlps_pkg.
module rlps_queue #(
   parameter int Depth = rlps_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rlps_pkg::cmd_type push_data,
   output logic              not_full,
   input  logic              pop,
   output rlps_pkg::cmd_type pop_data,
   output logic              not_empty
);
   import rlps_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type             slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff,  count_in;

   logic do_push, do_pop;

   assign not_full  = (count_ff != CntW'(Depth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/rlps_engine.sv =====
// Back end: timing registers, bit serializer state and the response register.
// Consumes one queued command per cycle unless a response stalls. Depends on rlps_pkg.
module rlps_engine (
   input  logic              clock,
   input  logic              reset,
   input  rlps_pkg::cmd_type cmd_in,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   rlps_csr_if.sink          csr_bus,
   rlps_rsp_if.source        rsp_bus
);
   import rlps_pkg::*;

   logic [TICK_W-1:0] zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;

   logic [PIXEL_BITS-1:0] shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]  bits_ff,  bits_in;
   logic                  high_ff,  high_in;
   logic [TICK_W-1:0]     ticks_ff, ticks_in;
   logic                  active_ff, active_in;
   logic                  taken;

   logic rsp_valid_ff, level_ff, taken_ff, sending_ff;

   // output register frees up as soon as its transfer completes
   assign cmd_pop       = cmd_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign csr_bus.ready = 1'b1;

   always_comb begin
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      high_in   = high_ff;
      ticks_in  = ticks_ff;
      active_in = active_ff;
      taken     = 1'b0;
      if (!cmd_in.is_tick) begin
         if (!active_ff) begin
            shift_in  = cmd_in.grb;
            bits_in   = BIT_CNT_W'(PIXEL_BITS);
            active_in = 1'b1;
            high_in   = 1'b1;
            ticks_in  = cmd_in.grb[PIXEL_BITS-1] ? one_high_ff : zero_high_ff;
            taken     = 1'b1;
         end
      end else if (active_ff) begin
         if (ticks_ff > TICK_W'(1)) begin
            ticks_in = ticks_ff - 1'b1;
         end else if (high_ff) begin
            high_in  = 1'b0;
            ticks_in = shift_ff[PIXEL_BITS-1] ? one_low_ff : zero_low_ff;
         end else begin
            shift_in = {shift_ff[PIXEL_BITS-2:0], 1'b0};
            bits_in  = bits_ff - 1'b1;
            if (bits_ff == BIT_CNT_W'(1)) begin
               active_in = 1'b0;
               high_in   = 1'b0;
               ticks_in  = '0;
            end else begin
               high_in  = 1'b1;
               ticks_in = shift_ff[PIXEL_BITS-2] ? one_high_ff : zero_high_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff <= ZERO_HIGH_RST;
         zero_low_ff  <= ZERO_LOW_RST;
         one_high_ff  <= ONE_HIGH_RST;
         one_low_ff   <= ONE_LOW_RST;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ZERO_HIGH: zero_high_ff <= csr_bus.data;
            CSR_ZERO_LOW:  zero_low_ff  <= csr_bus.data;
            CSR_ONE_HIGH:  one_high_ff  <= csr_bus.data;
            CSR_ONE_LOW:   one_low_ff   <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_ff      <= '0;
         high_ff      <= 1'b0;
         ticks_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_pop) begin
            shift_ff  <= shift_in;
            bits_ff   <= bits_in;
            high_ff   <= high_in;
            ticks_ff  <= ticks_in;
            active_ff <= active_in;
         end
         if (cmd_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         level_ff   <= active_in && high_in;
         taken_ff   <= taken;
         sending_ff <= active_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.line_level  = level_ff;
   assign rsp_bus.pixel_taken = taken_ff;
   assign rsp_bus.sending     = sending_ff;

`ifndef SYNTH
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (bits_ff == '0) && !high_ff && (ticks_ff == '0))
      else $error("idle serializer holds leftover bit state");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (bits_ff != '0) && (bits_ff <= BIT_CNT_W'(PIXEL_BITS)))
      else $error("bit count out of range while sending");

   a_taken_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && taken_ff |-> sending_ff && level_ff)
      else $error("accepted pixel not reported as sending high");

   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !cmd_pop)
      else $error("command consumed while response register is blocked");
`endif

endmodule
